>>> sv/cbt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the cubic Bezier tessellator.
// Used by cubic_bezier_tessellator; depends on nothing else.
package cbt_pkg;

  // One cubic segment: four 3-D control points, signed Q16.16
  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] out_handle_x;
    logic signed [31:0] out_handle_y;
    logic signed [31:0] out_handle_z;
    logic signed [31:0] in_handle_x;
    logic signed [31:0] in_handle_y;
    logic signed [31:0] in_handle_z;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic signed [31:0] end_z;
  } seg_t;

  // One curve point, signed Q16.16, with end-of-segment flag
  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic               last_point;
  } point_t;

  // Control coordinates regrouped by axis: [axis][control point]
  typedef logic [3:0][31:0] axis_pts_t;
  typedef axis_pts_t [2:0]  seg_pts_t;

  // Bernstein weights in Q0.48 (one extra bit so 1.0 fits)
  localparam int unsigned WgtW   = 49;
  localparam int unsigned WgtLoW = 24;
  localparam int unsigned WgtHiW = WgtW - WgtLoW;
  typedef logic [3:0][WgtW-1:0] wgt_t;

  // Parameter u in Q0.16, step register in unsigned Q1.16 (17 bits)
  localparam int unsigned UW    = 16;
  localparam int unsigned StepW = 17;
  localparam logic [StepW-1:0] StepMin   = 17'd1024;
  localparam logic [StepW-1:0] UOne      = 17'd65536;
  localparam logic [StepW-1:0] StepReset = 17'd6554;

  // Register map
  localparam int unsigned AddrW = 3;
  localparam logic RegParamStep = 1'b0;

  // Product and sum widths of the weighted sum
  localparam int unsigned ProdHiW = 32 + WgtHiW + 1;
  localparam int unsigned ProdLoW = 32 + WgtLoW + 1;
  localparam int unsigned SumHiW  = ProdHiW + 2;
  localparam int unsigned SumLoW  = ProdLoW + 2;
  localparam int unsigned AccW    = SumHiW + WgtLoW;
  localparam int unsigned RndShift = 2 * WgtLoW;
  localparam int unsigned RndW    = AccW - RndShift;

  // Regroup a segment request by axis
  function automatic seg_pts_t seg_to_pts(seg_t s);
    seg_pts_t p;
    p[0] = {s.end_x, s.in_handle_x, s.out_handle_x, s.start_x};
    p[1] = {s.end_y, s.in_handle_y, s.out_handle_y, s.start_y};
    p[2] = {s.end_z, s.in_handle_z, s.out_handle_z, s.start_z};
    return p;
  endfunction

endpackage

>>> sv/cubic_bezier_tessellator.sv
`timescale 1ns / 1ps
// Cubic Bezier segment tessellator: sequencer plus six-stage evaluation pipeline.
// Depends on cbt_pkg.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------------
//  in      | input     | in_valid_i / in_ready_o   | in_req_i  (cbt_pkg::seg_t)
//  out     | output    | out_valid_o / out_ready_i | out_rsp_o (cbt_pkg::point_t)
//  cfg     | input     | APB psel/penable/pready   | param_step at byte address 0
//
// A segment yields ceil(65536 / clamped step) points, one point per cycle from the sequencer
// while the output is not stalled; the next segment is taken in the cycle its
// predecessor issues its last point. Issued points pass in order through stage registers s1 to s6.
// Reset clears all valid bits and sets param_step to 6554.
// A stalled output freezes the whole pipeline and a busy sequencer; an idle sequencer can still take a segment.
module cubic_bezier_tessellator (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  cbt_pkg::seg_t             in_req_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output cbt_pkg::point_t           out_rsp_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [cbt_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import cbt_pkg::*;

  // ---------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------
  logic [StepW-1:0] step_q, step_d;
  logic [StepW-1:0] step_eff;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == RegParamStep);

  always_comb begin
    step_d = step_q;
    if (cfg_wr) begin
      step_d = pwdata[StepW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StepReset;
    end else begin
      step_q <= step_d;
    end
  end

  assign prdata = (paddr[2] == RegParamStep) ? 32'(step_q) : 32'd0;

  // Clamp step into the legal range
  always_comb begin
    step_eff = step_q;
    if (step_q < StepMin) begin
      step_eff = StepMin;
    end else if (step_q > UOne) begin
      step_eff = UOne;
    end
  end

  // ---------------------------------------------------------------
  // Sequencer: hold one segment and, unless stalled, issue one u per cycle
  // ---------------------------------------------------------------
  logic            adv;
  logic            in_fire;
  logic            issue;
  logic            busy_q, busy_d;
  logic [UW-1:0]   u_q, u_d;
  seg_pts_t        seg_q;
  logic [UW+1:0]   u_sum;
  logic            last_now;

  logic            s6_vld_q;

  assign adv      = !s6_vld_q || out_ready_i;
  assign u_sum    = (UW+2)'(u_q) + (UW+2)'(step_eff);
  assign last_now = (u_sum[UW+1:UW] != 2'b00);
  assign issue    = busy_q && adv;
  assign in_ready_o = !busy_q || (adv && last_now);
  assign in_fire  = in_valid_i && in_ready_o;

  always_comb begin
    busy_d = busy_q;
    u_d    = u_q;
    if (in_fire) begin
      busy_d = 1'b1;
      u_d    = '0;
    end else if (issue) begin
      u_d = u_sum[UW-1:0];
      if (last_now) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      u_q    <= '0;
    end else begin
      busy_q <= busy_d;
      u_q    <= u_d;
    end
  end

  // Load segment payload on request
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      seg_q <= seg_to_pts(in_req_i);
    end
  end

  // ---------------------------------------------------------------
  // Stage 1: u and 1-u
  // ---------------------------------------------------------------
  logic             s1_vld_q;
  logic [UW-1:0]    s1_u_q;
  logic [StepW-1:0] s1_w_q;
  logic             s1_last_q;
  seg_pts_t         s1_pts_q;

  // Stage 2: squares
  logic             s2_vld_q;
  logic [UW-1:0]    s2_u_q;
  logic [StepW-1:0] s2_w_q;
  logic [2*StepW-1:0] s2_w2_q, s2_w2_d;
  logic [2*UW-1:0]    s2_u2_q, s2_u2_d;
  logic             s2_last_q;
  seg_pts_t         s2_pts_q;

  // Stage 3: Bernstein weights
  logic             s3_vld_q;
  wgt_t             s3_wgt_q, s3_wgt_d;
  logic             s3_last_q;
  seg_pts_t         s3_pts_q;

  // Stage 4: partial products
  logic                      s4_vld_q;
  logic signed [ProdHiW-1:0] s4_hi_q [3][4];
  logic signed [ProdHiW-1:0] s4_hi_d [3][4];
  logic signed [ProdLoW-1:0] s4_lo_q [3][4];
  logic signed [ProdLoW-1:0] s4_lo_d [3][4];
  logic                      s4_last_q;

  // Stage 5: per-axis sums
  logic                     s5_vld_q;
  logic signed [SumHiW-1:0] s5_hi_q [3];
  logic signed [SumHiW-1:0] s5_hi_d [3];
  logic signed [SumLoW-1:0] s5_lo_q [3];
  logic signed [SumLoW-1:0] s5_lo_d [3];
  logic                     s5_last_q;

  // Stage 6: rounded, saturated output register
  logic [2:0][31:0] s6_pt_q, s6_pt_d;
  logic             s6_last_q;

  // Squares of u and 1-u
  always_comb begin
    s2_w2_d = (2*StepW)'(s1_w_q) * (2*StepW)'(s1_w_q);
    s2_u2_d = (2*UW)'(s1_u_q) * (2*UW)'(s1_u_q);
  end

  // Weights: w^3, 3 w^2 u, 3 w u^2, u^3
  always_comb begin
    logic [WgtW+1:0] t1;
    logic [WgtW+1:0] t2;
    t1 = (WgtW+2)'(s2_w2_q) * (WgtW+2)'(s2_u_q);
    t2 = (WgtW+2)'(s2_u2_q) * (WgtW+2)'(s2_w_q);
    s3_wgt_d[0] = WgtW'((WgtW+2)'(s2_w2_q) * (WgtW+2)'(s2_w_q));
    s3_wgt_d[1] = WgtW'(t1 + (t1 << 1));
    s3_wgt_d[2] = WgtW'(t2 + (t2 << 1));
    s3_wgt_d[3] = WgtW'((WgtW+2)'(s2_u2_q) * (WgtW+2)'(s2_u_q));
  end

  // Split each weight into high and low halves and multiply
  always_comb begin
    logic signed [ProdHiW-1:0] p_hi;
    logic signed [ProdLoW-1:0] p_lo;
    logic signed [ProdHiW-1:0] w_hi;
    logic signed [ProdLoW-1:0] w_lo;
    for (int a = 0; a < 3; a++) begin
      for (int k = 0; k < 4; k++) begin
        p_hi = ProdHiW'($signed(s3_pts_q[a][k]));
        p_lo = ProdLoW'($signed(s3_pts_q[a][k]));
        w_hi = $signed(ProdHiW'(s3_wgt_q[k][WgtW-1:WgtLoW]));
        w_lo = $signed(ProdLoW'(s3_wgt_q[k][WgtLoW-1:0]));
        s4_hi_d[a][k] = p_hi * w_hi;
        s4_lo_d[a][k] = p_lo * w_lo;
      end
    end
  end

  // Sum the four control-point terms per axis
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      s5_hi_d[a] = SumHiW'(s4_hi_q[a][0]) + SumHiW'(s4_hi_q[a][1])
                 + SumHiW'(s4_hi_q[a][2]) + SumHiW'(s4_hi_q[a][3]);
      s5_lo_d[a] = SumLoW'(s4_lo_q[a][0]) + SumLoW'(s4_lo_q[a][1])
                 + SumLoW'(s4_lo_q[a][2]) + SumLoW'(s4_lo_q[a][3]);
    end
  end

  // Merge halves, round half up, saturate to 32 bits
  always_comb begin
    logic signed [AccW-1:0] acc;
    logic signed [RndW-1:0] r;
    for (int a = 0; a < 3; a++) begin
      acc = (AccW'(s5_hi_q[a]) <<< WgtLoW) + AccW'(s5_lo_q[a])
          + (AccW'(1) <<< (RndShift - 1));
      r = acc[AccW-1:RndShift];
      if (r[RndW-1:31] == '0 || r[RndW-1:31] == '1) begin
        s6_pt_d[a] = r[31:0];
      end else if (r[RndW-1]) begin
        s6_pt_d[a] = 32'h8000_0000;
      end else begin
        s6_pt_d[a] = 32'h7FFF_FFFF;
      end
    end
  end

  // Advance valid bits together with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
      s5_vld_q <= 1'b0;
      s6_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= busy_q;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
      s5_vld_q <= s4_vld_q;
      s6_vld_q <= s5_vld_q;
    end
  end

  // Advance payload; hold everything on a stall
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_u_q    <= u_q;
      s1_w_q    <= UOne - StepW'(u_q);
      s1_last_q <= last_now;
      s1_pts_q  <= seg_q;

      s2_u_q    <= s1_u_q;
      s2_w_q    <= s1_w_q;
      s2_w2_q   <= s2_w2_d;
      s2_u2_q   <= s2_u2_d;
      s2_last_q <= s1_last_q;
      s2_pts_q  <= s1_pts_q;

      s3_wgt_q  <= s3_wgt_d;
      s3_last_q <= s2_last_q;
      s3_pts_q  <= s2_pts_q;

      s4_hi_q   <= s4_hi_d;
      s4_lo_q   <= s4_lo_d;
      s4_last_q <= s3_last_q;

      s5_hi_q   <= s5_hi_d;
      s5_lo_q   <= s5_lo_d;
      s5_last_q <= s4_last_q;

      s6_pt_q   <= s6_pt_d;
      s6_last_q <= s5_last_q;
    end
  end

  assign out_valid_o          = s6_vld_q;
  assign out_rsp_o.point_x    = s6_pt_q[0];
  assign out_rsp_o.point_y    = s6_pt_q[1];
  assign out_rsp_o.point_z    = s6_pt_q[2];
  assign out_rsp_o.last_point = s6_last_q;

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  // A new segment always starts at u = 0
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (busy_q && u_q == '0))
    else $error("segment did not restart at u = 0");

  // Issuing the last point without a new request leaves the sequencer idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue && last_now && !in_fire) |=> !busy_q)
    else $error("sequencer stayed busy after last point");

  // Effective step stays within 1/64 .. 1
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_eff >= StepMin) && (step_eff <= UOne))
    else $error("step outside clamp range");

  // A stall freezes every valid bit of the pipeline
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable({s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q, s5_vld_q, s6_vld_q}))
    else $error("pipeline moved during stall");

  // No request is taken while a segment is still mid-way and not finishing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !(adv && last_now)) |-> !in_ready_o)
    else $error("request accepted over a running segment");

endmodule

>>> test/tb_cubic_bezier_tessellator.sv
`timescale 1ns / 1ps
// Self-checking testbench for cubic_bezier_tessellator: drives segment requests and APB
// step writes, predicts every curve point in exact integer math. Depends on cbt_pkg.
module tb_cubic_bezier_tessellator;
  import cbt_pkg::*;

  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned SettleDelay = 12;
  localparam int unsigned MaxPoints   = 64;
  localparam int unsigned MaxShown    = 40;
  localparam int unsigned HoldStretch = 300;
  localparam logic [AddrW-1:0] StepAddr  = AddrW'(4 * RegParamStep);
  localparam logic [AddrW-1:0] SpareAddr = AddrW'(4);
  localparam logic [31:0] CoordMax = 32'h7FFF_FFFF;
  localparam logic [31:0] CoordMin = 32'h8000_0000;

  // Expected curve points of accepted segments, plus the step register copy
  class curve_point_tracker;
    logic [StepW-1:0] step_reg;
    point_t           pending_points[$];
    int unsigned      mismatches;

    function new();
      step_reg   = StepReset;
      mismatches = 0;
    endfunction

    function void set_step(logic [31:0] value);
      step_reg = value[StepW-1:0];
    endfunction

    task report_mismatch(string msg);
      if (mismatches < MaxShown) $display("%0t ns mismatch: %s", $realtime, msg);
      mismatches++;
    endtask

    // Form the exact weighted sum (Q16.16 times Q0.48), round half up, saturate
    function logic signed [31:0] blend_axis(logic signed [31:0] p [4],
                                            longint unsigned wgt [4]);
      logic signed [95:0] acc;
      acc = '0;
      for (int k = 0; k < 4; k++) acc = acc + 96'(p[k]) * 96'(wgt[k]);
      acc = (acc + (96'sd1 <<< 47)) >>> 48;
      if (acc > 96'sd2147483647) return CoordMax;
      if (acc < -96'sd2147483648) return CoordMin;
      return acc[31:0];
    endfunction

    // Expand one accepted segment request into its curve points
    function void add_segment(seg_t s);
      int unsigned        step;
      int unsigned        u;
      int unsigned        n;
      longint unsigned    uu;
      longint unsigned    w;
      longint unsigned    wgt [4];
      logic signed [31:0] cx [4];
      logic signed [31:0] cy [4];
      logic signed [31:0] cz [4];
      point_t             pt;
      step = step_reg;
      if (step < StepMin) step = StepMin;
      if (step > UOne) step = UOne;
      cx = '{s.start_x, s.out_handle_x, s.in_handle_x, s.end_x};
      cy = '{s.start_y, s.out_handle_y, s.in_handle_y, s.end_y};
      cz = '{s.start_z, s.out_handle_z, s.in_handle_z, s.end_z};
      u = 0;
      n = 0;
      while (u < UOne && n < MaxPoints) begin
        uu = u;
        w = 64'(UOne) - uu;
        wgt[0] = w * w * w;
        wgt[1] = 3 * w * w * uu;
        wgt[2] = 3 * w * uu * uu;
        wgt[3] = uu * uu * uu;
        pt.point_x = blend_axis(cx, wgt);
        pt.point_y = blend_axis(cy, wgt);
        pt.point_z = blend_axis(cz, wgt);
        pt.last_point = (u + step >= UOne);
        pending_points.insert(pending_points.size(), pt);
        u += step;
        n++;
      end
    endfunction

    // Compare one accepted point with the oldest expectation
    task check_point(point_t got);
      point_t want;
      if (pending_points.size() == 0) begin
        report_mismatch($sformatf("unexpected point (%0d,%0d,%0d,last=%0b)",
                                  got.point_x, got.point_y, got.point_z, got.last_point));
        return;
      end
      want = pending_points.pop_front();
      if (got.point_x !== want.point_x || got.point_y !== want.point_y ||
          got.point_z !== want.point_z || got.last_point !== want.last_point)
        report_mismatch($sformatf("got (%0d,%0d,%0d,last=%0b) want (%0d,%0d,%0d,last=%0b)",
                                  got.point_x, got.point_y, got.point_z, got.last_point,
                                  want.point_x, want.point_y, want.point_z,
                                  want.last_point));
    endtask
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  seg_t               in_req = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  point_t             out_rsp;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [AddrW-1:0]   paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  curve_point_tracker tracker = new();
  int unsigned        cycles = 0;
  bit                 rx_idle = 1'b1;
  int unsigned        hold_cycles = 0;
  seg_t               last_seg = '0;

  cubic_bezier_tessellator i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_rsp_o   (out_rsp),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb_cubic_bezier_tessellator: FAIL");
      $finish;
    end
  end

  // Check every accepted point
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) tracker.check_point(out_rsp);
  end

  // Drive out_ready: random stalls per point while rx_idle is set, plus a long hold when requested
  initial begin
    int unsigned gap;
    @(posedge rst_ni);
    forever begin
      if (hold_cycles != 0) begin
        gap = hold_cycles;
        hold_cycles = 0;
      end else begin
        gap = rx_idle ? $urandom_range(0, 15) : 0;
      end
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid);
    end
  end

  // Mostly full-range values, with extremes and small magnitudes mixed in
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 7))
      0: return CoordMax;
      1: return CoordMin;
      2: return 32'($urandom_range(0, 262144));
      3: return -32'($urandom_range(0, 262144));
      default: return $urandom();
    endcase
  endfunction

  // Build a random segment, often continuing from the previous end knot
  function automatic seg_t rand_segment(seg_t prev);
    seg_t s;
    s = {rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
         rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord()};
    if ($urandom_range(0, 1) == 1) begin
      s.start_x = prev.end_x;
      s.start_y = prev.end_y;
      s.start_z = prev.end_z;
    end
    return s;
  endfunction

  // Same value on every axis of each control point
  function automatic seg_t flat_segment(logic [31:0] p0, logic [31:0] p1,
                                        logic [31:0] p2, logic [31:0] p3);
    return {p0, p0, p0, p1, p1, p1, p2, p2, p2, p3, p3, p3};
  endfunction

  // Offer one segment request and hold it until accepted
  task automatic send_segment(input seg_t s, input bit tx_idle);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 15) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_req   <= s;
    do @(posedge clk_i); while (!in_ready);
    tracker.add_segment(s);
    last_seg = s;
  endtask

  // Drop valid and wait until every expected point has come out
  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.pending_points.size() != 0) @(posedge clk_i);
    repeat (SettleDelay) @(posedge clk_i);
  endtask

  // One APB transfer: setup, access, then idle with psel low
  task automatic apb_access(input logic write, input logic [AddrW-1:0] addr,
                            input logic [31:0] data, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata   = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Write a register while idle, then read the step back
  task automatic write_reg(input logic [AddrW-1:0] addr, input logic [31:0] data);
    logic [31:0] rdata;
    settle();
    apb_access(1'b1, addr, data, rdata);
    if (addr == StepAddr) tracker.set_step(data);
    apb_access(1'b0, StepAddr, '0, rdata);
    if (rdata !== 32'(tracker.step_reg))
      tracker.report_mismatch($sformatf("step readback %0d want %0d", rdata,
                                        tracker.step_reg));
  endtask

  task automatic run_phase(input logic [31:0] step_word, input int unsigned n_items,
                           input bit tx_idle, input bit rx_idle_v,
                           input int unsigned hold);
    write_reg(StepAddr, step_word);
    rx_idle = rx_idle_v;
    hold_cycles = hold;
    for (int unsigned i = 0; i < n_items; i++) send_segment(rand_segment(last_seg), tx_idle);
  endtask

  initial begin
    logic [31:0] rdata;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Check the reset step, then push extremes through it
    apb_access(1'b0, StepAddr, '0, rdata);
    if (rdata !== 32'(StepReset))
      tracker.report_mismatch($sformatf("reset step readback %0d", rdata));
    send_segment(flat_segment('0, '0, '0, '0), 1'b1);
    send_segment(flat_segment(CoordMax, CoordMax, CoordMax, CoordMax), 1'b1);
    send_segment(flat_segment(CoordMin, CoordMin, CoordMin, CoordMin), 1'b1);
    send_segment(flat_segment(CoordMin, CoordMax, CoordMin, CoordMax), 1'b0);
    send_segment(flat_segment(CoordMax, CoordMin, CoordMax, CoordMin), 1'b0);
    send_segment(flat_segment(32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 32'd1), 1'b1);
    send_segment(rand_segment(last_seg), 1'b1);

    // Small step clamps to the minimum; a step of 1.0 or more leaves only u = 0
    write_reg(StepAddr, 32'd0);
    send_segment(rand_segment(last_seg), 1'b1);
    write_reg(StepAddr, 32'd1023);
    send_segment(rand_segment(last_seg), 1'b0);
    write_reg(StepAddr, 32'd1024);
    send_segment(flat_segment(CoordMax, CoordMin, CoordMax, CoordMin), 1'b1);
    write_reg(StepAddr, 32'd65535);
    send_segment(rand_segment(last_seg), 1'b1);
    write_reg(StepAddr, 32'd65536);
    send_segment(rand_segment(last_seg), 1'b1);
    write_reg(StepAddr, 32'd65537);
    send_segment(rand_segment(last_seg), 1'b1);
    write_reg(StepAddr, 32'hFFFF_FFFF);
    send_segment(rand_segment(last_seg), 1'b1);

    // Ignore a write to an unmapped register index
    write_reg(SpareAddr, 32'd2048);
    send_segment(rand_segment(last_seg), 1'b1);

    // Random segments over a range of steps; the long hold fills the pipeline
    run_phase(32'd65536, 12, 1'b1, 1'b1, 0);
    run_phase(32'd1024, 12, 1'b0, 1'b0, HoldStretch);
    run_phase(32'($urandom_range(1024, 65536)), 12, 1'b1, 1'b1, 0);
    run_phase({15'($urandom()), 17'($urandom_range(0, 131071))}, 12, 1'b1, 1'b0, 0);
    run_phase(32'(StepReset), 12, 1'b0, 1'b0, 0);
    run_phase(32'($urandom_range(1024, 4096)), 12, 1'b1, 1'b1, 0);
    run_phase(32'd131071, 12, 1'b0, 1'b1, 0);
    run_phase(32'($urandom_range(1024, 65536)), 12, 1'b1, 1'b1, 0);

    settle();
    if (tracker.mismatches == 0 && tracker.pending_points.size() == 0)
      $display("tb_cubic_bezier_tessellator: PASS");
    else
      $display("tb_cubic_bezier_tessellator: FAIL");
    $finish;
  end

endmodule
